FILE: sv/pcmcv_pkg.sv
// Package for the PCM sample to signed 16-bit converter.
// Holds the source format codes, the register map and the conversion result type.
// No dependencies.
package pcmcv_pkg;

	localparam int unsigned SampleBytesW = 32;
	localparam int unsigned SampleW      = 16;
	localparam int unsigned FmtW         = 3;
	localparam int unsigned ApbAddrW     = 3;
	localparam int unsigned ApbDataW     = 32;

	typedef enum logic [FmtW-1:0] {
		FMT_U8    = 3'd0,
		FMT_S16LE = 3'd1,
		FMT_S16BE = 3'd2,
		FMT_S24LE = 3'd3,
		FMT_S24BE = 3'd4,
		FMT_F32LE = 3'd5,
		FMT_F32BE = 3'd6
	} fmt_t;

	localparam logic [FmtW-1:0] FmtReset = FMT_S16LE;

	// Register index of source_format in the configuration map.
	localparam logic RegSourceFormat = 1'b0;

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic               clipped;
	} conv_res_t;

endpackage

FILE: sv/pcmcv_convert.sv
// Combinational sample conversion for the PCM to signed 16-bit converter.
// Integer formats are byte selection; float formats scale by 32767 with rounding.
// Depends on pcmcv_pkg.
module pcmcv_convert (
	input  logic [pcmcv_pkg::SampleBytesW-1:0] sample_bytes,
	input  logic [pcmcv_pkg::FmtW-1:0]         fmt,
	output pcmcv_pkg::conv_res_t               res
);

	logic [7:0]  b0, b1, b2, b3;
	logic [31:0] fbits;
	logic        fsign;
	logic [7:0]  fexp;
	logic [23:0] mant;
	logic [38:0] prod;
	logic [24:0] kept;
	logic        rnd_up;
	logic [39:0] rounded;
	logic [8:0]  shamt;
	logic [39:0] ival;
	logic        ge_32768, gt_32768;
	logic [15:0] fsample;
	logic        fclip;

	assign b0 = sample_bytes[7:0];
	assign b1 = sample_bytes[15:8];
	assign b2 = sample_bytes[23:16];
	assign b3 = sample_bytes[31:24];

	always_comb begin
		if (fmt == pcmcv_pkg::FMT_F32BE) begin
			fbits = {b0, b1, b2, b3};
		end else begin
			fbits = sample_bytes;
		end
	end

	assign fsign = fbits[31];
	assign fexp  = fbits[30:23];
	assign mant  = {1'b1, fbits[22:0]};

	// m * 32767 is exact in 39 bits; its top bit is bit 38 or bit 37.
	assign prod = {mant, 15'd0} - {15'd0, mant};

	always_comb begin
		if (prod[38]) begin
			rnd_up  = prod[14] & ((|prod[13:0]) | prod[15]);
			kept    = {1'b0, prod[38:15]} + {24'd0, rnd_up};
			rounded = {kept, 15'd0};
		end else begin
			rnd_up  = prod[13] & ((|prod[12:0]) | prod[14]);
			kept    = {1'b0, prod[37:14]} + {24'd0, rnd_up};
			rounded = {1'b0, kept, 14'd0};
		end
	end

	// Value is rounded * 2^(e-150); the integer part is a right shift.
	assign shamt = 9'd150 - {1'b0, fexp};

	always_comb begin
		if (fexp == 8'd0 || shamt >= 9'd40) begin
			ival = '0;
		end else begin
			ival = rounded >> shamt[5:0];
		end
	end

	assign ge_32768 = (|ival[39:16]) | ival[15];
	assign gt_32768 = (|ival[39:16]) | (ival[15] & (|ival[14:0]));

	always_comb begin
		fclip   = 1'b0;
		fsample = '0;
		if (fexp == 8'hFF && fbits[22:0] != 23'd0) begin
			fclip = 1'b1;
		end else if (!fsign) begin
			if (fexp == 8'hFF || fexp > 8'd150 || ge_32768) begin
				fclip   = 1'b1;
				fsample = 16'h7FFF;
			end else begin
				fsample = ival[15:0];
			end
		end else begin
			if (fexp == 8'hFF || fexp > 8'd150 || gt_32768) begin
				fclip   = 1'b1;
				fsample = 16'h8000;
			end else begin
				fsample = 16'd0 - ival[15:0];
			end
		end
	end

	always_comb begin
		res.clipped = 1'b0;
		case (fmt)
			pcmcv_pkg::FMT_U8:    res.sample = {~b0[7], b0[6:0], b0};
			pcmcv_pkg::FMT_S16LE: res.sample = {b1, b0};
			pcmcv_pkg::FMT_S16BE: res.sample = {b0, b1};
			pcmcv_pkg::FMT_S24LE: res.sample = {b2, b1};
			pcmcv_pkg::FMT_S24BE: res.sample = {b0, b1};
			pcmcv_pkg::FMT_F32LE, pcmcv_pkg::FMT_F32BE: begin
				res.sample  = fsample;
				res.clipped = fclip;
			end
			default:              res.sample = '0;
		endcase
	end

endmodule

FILE: sv/pcm_sample_to_s16_converter.sv
// Top level of the PCM sample to signed 16-bit converter.
// Input register, conversion logic, result register and the APB register port.
// Depends on pcmcv_pkg and pcmcv_convert.
//
// Usage:
// The slave stream takes one raw sample per beat on s_tdata (first byte in
// bits 7:0) with s_tlast marking the final sample of a buffer. The master
// stream returns the signed 16-bit sample on m_tdata, the clip flag on
// m_tuser and the copied marker on m_tlast. The source format is set over
// the APB port at address 0 and should only be changed while the block is
// empty. An accepted input beat passes the input register and then the result
// register; one beat is accepted every cycle unless the receiver stalls, the
// conversion being a single registered pass with no state between samples. At
// reset both stages empty and the format returns to s16 little endian. When the
// receiver stalls, the result holds on the master side and the input register
// still takes one more beat before s_tready falls.
module pcm_sample_to_s16_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [pcmcv_pkg::SampleBytesW-1:0] s_tdata,  // sample_bytes[31:0]
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [pcmcv_pkg::SampleW-1:0]      m_tdata,  // sample_out[15:0]
	output logic                               m_tuser,  // clipped
	output logic                               m_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pcmcv_pkg::ApbAddrW-1:0]     paddr,
	input  logic [pcmcv_pkg::ApbDataW-1:0]     pwdata,
	output logic [pcmcv_pkg::ApbDataW-1:0]     prdata,
	output logic                               pready
);

	logic [pcmcv_pkg::FmtW-1:0]         fmt_q;
	logic                               valid_s1;
	logic [pcmcv_pkg::SampleBytesW-1:0] bytes_s1;
	logic                               last_s1;
	logic                               adv_s1;
	pcmcv_pkg::conv_res_t               conv;

	assign pready = 1'b1;
	assign prdata = {{(pcmcv_pkg::ApbDataW-pcmcv_pkg::FmtW){1'b0}}, fmt_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= pcmcv_pkg::FmtReset;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == pcmcv_pkg::RegSourceFormat) begin
			fmt_q <= pwdata[pcmcv_pkg::FmtW-1:0];
		end
	end

	// The first stage moves on whenever the result register is free or drains.
	assign adv_s1   = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			bytes_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	pcmcv_convert u_convert (
		.sample_bytes (bytes_s1),
		.fmt          (fmt_q),
		.res          (conv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_tdata <= conv.sample;
			m_tuser <= conv.clipped;
			m_tlast <= last_s1;
		end
	end

endmodule

FILE: sv/pcmcv_checker.sv
// Port-level checker for the PCM sample to signed 16-bit converter.
// Bound to the top level; depends only on the top level's ports.
module pcmcv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic [31:0] prdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 16'h7FFF || m_tdata == 16'h8000
			|| m_tdata == 16'h0000))
		else $error("clipped beat carries a non-saturated value");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with an empty result register");

	a_prdata: assert property (@(posedge clk) disable iff (!arst_n)
		prdata[31:3] == 29'd0)
		else $error("unused register bits read as non-zero");

endmodule

bind pcm_sample_to_s16_converter pcmcv_checker u_pcmcv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.prdata   (prdata)
);

FILE: verif/pcm_sample_to_s16_converter_tb.sv
// Testbench for the PCM sample to signed 16-bit converter.
// Drives raw sample beats through every source format and checks each result beat
// against a predictor built in this file. Depends on pcmcv_pkg and the converter RTL.
`timescale 1ns / 100ps

module pcm_sample_to_s16_converter_tb;

	typedef struct {
		logic [31:0] bytes;
		logic        last;
	} raw_sample_t;

	typedef struct {
		logic [15:0] sample;
		logic        clipped;
		logic        last;
	} s16_sample_t;

	localparam int CycleLimit = 300000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [pcmcv_pkg::ApbAddrW-1:0] paddr;
	logic [pcmcv_pkg::ApbDataW-1:0] pwdata;
	logic [pcmcv_pkg::ApbDataW-1:0] prdata;
	logic        pready;

	raw_sample_t pending_samples[$];
	s16_sample_t expected_samples[$];
	raw_sample_t driven_sample;
	logic [pcmcv_pkg::FmtW-1:0] shadow_format;
	int  errors;
	int  cycles;
	int  send_gap;
	int  recv_stall;
	bit  no_idle;

	pcm_sample_to_s16_converter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // sample_bytes[31:0]
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // sample_out[15:0]
		.m_tuser  (m_tuser),   // clipped
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [31:0] swap_bytes(logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	// Returns {clipped, sample}. The product is exact in 64 bits and is then
	// rounded to a 24-bit significand, nearest even, as binary32 would do.
	function automatic logic [16:0] float_to_s16(logic [31:0] b);
		logic        sgn;
		int          expo;
		int          sh;
		int          ex;
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] mag;
		sgn  = b[31];
		expo = int'(b[30:23]);
		if (expo == 255) begin
			if (b[22:0] != 0)
				return {1'b1, 16'h0000};
			return sgn ? {1'b1, 16'h8000} : {1'b1, 16'h7FFF};
		end
		// Subnormal inputs give a product far below one.
		if (expo == 0)
			return 17'h0;
		p    = 64'({1'b1, b[22:0]}) * 64'd32767;
		sh   = p[38] ? 15 : 14;
		q    = p >> sh;
		rem  = p & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 1;
		if (q[24]) begin
			q  = q >> 1;
			sh = sh + 1;
		end
		ex = expo - 150 + sh;
		if (ex > 20)
			mag = 64'hFFFF_FFFF;
		else if (ex >= 0)
			mag = q << ex;
		else if (ex < -40)
			mag = 0;
		else
			mag = q >> (-ex);
		if (!sgn)
			return (mag >= 32768) ? {1'b1, 16'h7FFF} : {1'b0, mag[15:0]};
		if (mag >= 32769)
			return {1'b1, 16'h8000};
		return {1'b0, 16'(-mag)};
	endfunction

	function automatic s16_sample_t convert_sample(logic [pcmcv_pkg::FmtW-1:0] fmt,
			raw_sample_t r);
		s16_sample_t res;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [7:0]  b2;
		logic [16:0] fres;
		b0 = r.bytes[7:0];
		b1 = r.bytes[15:8];
		b2 = r.bytes[23:16];
		res.clipped = 1'b0;
		res.last    = r.last;
		case (fmt)
			pcmcv_pkg::FMT_U8:    res.sample = {b0, b0} ^ 16'h8000;
			pcmcv_pkg::FMT_S16LE: res.sample = {b1, b0};
			pcmcv_pkg::FMT_S16BE: res.sample = {b0, b1};
			pcmcv_pkg::FMT_S24LE: res.sample = {b2, b1};
			pcmcv_pkg::FMT_S24BE: res.sample = {b0, b1};
			pcmcv_pkg::FMT_F32LE: begin
				fres = float_to_s16(r.bytes);
				{res.clipped, res.sample} = fres;
			end
			pcmcv_pkg::FMT_F32BE: begin
				fres = float_to_s16(swap_bytes(r.bytes));
				{res.clipped, res.sample} = fres;
			end
			default:              res.sample = 16'h0000;
		endcase
		return res;
	endfunction

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 8);
	endfunction

	// Source side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_samples.push_back(convert_sample(shadow_format, driven_sample));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					driven_sample = pending_samples.pop_front();
					s_tdata  <= driven_sample.bytes;
					s_tlast  <= driven_sample.last;
					s_tvalid <= 1'b1;
					send_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					s16_sample_t exp_s;
					exp_s = expected_samples.pop_front();
					if (m_tdata !== exp_s.sample) begin
						$display("%0t: sample_out: expected %h, actual %h",
							$time, exp_s.sample, m_tdata);
						errors++;
					end
					if (m_tuser !== exp_s.clipped) begin
						$display("%0t: clipped: expected %b, actual %b",
							$time, exp_s.clipped, m_tuser);
						errors++;
					end
					if (m_tlast !== exp_s.last) begin
						$display("%0t: last_out: expected %b, actual %b",
							$time, exp_s.last, m_tlast);
						errors++;
					end
				end
				recv_stall = draw_gap();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("pcm_sample_to_s16_converter regression: fail");
			$finish;
		end
	end

	task automatic write_format(logic [pcmcv_pkg::FmtW-1:0] fmt);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= pcmcv_pkg::ApbAddrW'(4 * pcmcv_pkg::RegSourceFormat);
		pwdata  <= pcmcv_pkg::ApbDataW'(fmt);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		shadow_format = fmt;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || s_tvalid || expected_samples.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_sample(logic [31:0] w);
		raw_sample_t r;
		r.bytes = w;
		r.last  = 1'($urandom);
		pending_samples.push_back(r);
	endtask

	function automatic logic [31:0] random_word(logic [pcmcv_pkg::FmtW-1:0] fmt);
		logic [31:0] w;
		w = $urandom;
		// Mostly floats of moderate size so that rounding and clipping are hit.
		if ((fmt == pcmcv_pkg::FMT_F32LE || fmt == pcmcv_pkg::FMT_F32BE)
				&& $urandom_range(0, 3) != 0) begin
			w[30:23] = 8'($urandom_range(100, 142));
			if (fmt == pcmcv_pkg::FMT_F32BE)
				w = swap_bytes(w);
		end
		return w;
	endfunction

	initial begin
		logic [31:0] specials[$];
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		errors     = 0;
		cycles     = 0;
		send_gap   = 0;
		recv_stall = 0;
		no_idle    = 1'b0;
		shadow_format = pcmcv_pkg::FmtReset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset format first, then floats at the edges of the range.
		queue_sample(32'hFFFF_FFFF);
		queue_sample(32'h0000_8000);
		drain();
		specials = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
			32'h3F80_0100, 32'hBF80_0100, 32'hBF80_0200, 32'h7F80_0000,
			32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h3F00_0000, 32'hBF7F_FFFF};
		write_format(pcmcv_pkg::FMT_F32LE);
		foreach (specials[i]) queue_sample(specials[i]);
		drain();
		write_format(pcmcv_pkg::FMT_F32BE);
		for (int i = 0; i < 4; i++) queue_sample(swap_bytes(specials[i + 4]));
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			logic [pcmcv_pkg::FmtW-1:0] fmt;
			fmt = pcmcv_pkg::FmtW'(ph % 8);
			no_idle = (ph % 5 == 2);
			write_format(fmt);
			for (int i = 0; i < 88; i++) queue_sample(random_word(fmt));
			drain();
		end

		if (errors == 0)
			$display("pcm_sample_to_s16_converter regression: pass");
		else
			$display("pcm_sample_to_s16_converter regression: fail");
		$finish;
	end

endmodule
